[rtl/rbma_pkg.sv]
// ----------------------------------------------------------------------------
// rbma_pkg
// Shared constants and types for the ring buffer moving average block.
// ----------------------------------------------------------------------------
package rbma_pkg;

	// default sizing
	localparam int MAX_WINDOW_DEF  = 128;
	localparam int SAMPLE_BITS_DEF = 12;

	// fixed field widths
	localparam int CFG_W  = 8;
	localparam int SLOT_W = 7;

	// window length after reset
	localparam int WINDOW_RESET = 16;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[rtl/rbma_ram.sv]
// ----------------------------------------------------------------------------
// rbma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbma_ram #(
	parameter int WIDTH = rbma_pkg::SAMPLE_BITS_DEF,
	parameter int DEPTH = rbma_pkg::MAX_WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/rbma_div.sv]
// ----------------------------------------------------------------------------
// rbma_div
// Restoring divider, one quotient bit per cycle. Quotient holds after done.
// ----------------------------------------------------------------------------
module rbma_div #(
	parameter int DVD_W = 19,
	parameter int DVS_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_W-1:0]    dividend,
	input  logic [DVS_W-1:0]    divisor,
	output logic [DVD_W-1:0]    quotient,
	output rbma_pkg::div_status_t status
);

	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam int REM_W = DVS_W + 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [REM_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [REM_W-1:0] rem_sh;
	logic             ge;

	// remainder stays below the divisor, so its top bit is always clear
	assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

[rtl/ring_buffer_moving_average_top.sv]
// ----------------------------------------------------------------------------
// ring_buffer_moving_average_top
// Boxcar moving average over a ring of converter samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, sample_value): one sample per transfer.
//   Output channel (out_valid / out_stall, window_average, slot_written): one
//   result per input transfer, in order.
//   Each sample overwrites one ring slot; the running sum is updated
//   (minus old slot, plus new sample) and divided by the window length.
//   The sample passes the slot read-modify-write (ST_RD), then the
//   bit-serial divider, one quotient bit per cycle, then the output
//   register. The block takes no new sample until the divider is done
//   with the last one and its quotient has left the divider.
//   in_stall is high while a sample is in flight. A finished result sits in
//   the output register; a new sample is taken while it waits there. If the
//   receiver stalls long enough, the next result waits in the divider.
//   Reset: window length 16, ring, sum and write position cleared.
//   A cfg_wr_en write (idle only, a user rule; unchecked) sets the window
//   length, saturated to 1..MAX_WINDOW, and clears ring, sum and position
//   in the same cycle (per-slot valid bits; the RAM itself is never swept).
// ----------------------------------------------------------------------------
module ring_buffer_moving_average_top #(
	parameter int MAX_WINDOW  = rbma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = rbma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_wr_en,
	input  logic [rbma_pkg::CFG_W-1:0] cfg_wr_data,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SAMPLE_BITS-1:0]     sample_value,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [SAMPLE_BITS-1:0]     window_average,
	output logic [rbma_pkg::SLOT_W-1:0] slot_written
);

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int WIN_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_BITS + PTR_W;
	localparam int WIN_RST = (rbma_pkg::WINDOW_RESET > MAX_WINDOW) ?
		MAX_WINDOW : rbma_pkg::WINDOW_RESET;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0; // waiting for a sample
	localparam logic [1:0] ST_RD   = 2'd1; // old slot value on RAM output
	localparam logic [1:0] ST_DIV  = 2'd2; // divider running
	localparam logic [1:0] ST_HOLD = 2'd3; // quotient waits for output register

	logic [1:0]            state_q;
	logic [WIN_W-1:0]      win_q;
	logic [PTR_W-1:0]      pos_q;
	logic [SUM_W-1:0]      sum_q;
	logic [MAX_WINDOW-1:0] slot_vld_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [PTR_W-1:0]      slot_q;

	logic                  out_valid_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [rbma_pkg::SLOT_W-1:0] slot_out_q;

	logic                  in_xfer;
	logic                  out_free;
	logic [SAMPLE_BITS-1:0] ram_rd_data;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]      sum_new;
	logic [WIN_W-1:0]      pos_inc;
	logic [WIN_W-1:0]      win_cfg;
	logic                  div_start;
	logic [SUM_W-1:0]      div_quo;
	rbma_pkg::div_status_t div_stat;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	// output register can take a new result this cycle
	assign out_free = !out_valid_q || !out_stall;

	// saturate the written window length to 1..MAX_WINDOW
	always_comb begin
		priority if (cfg_wr_data == '0) begin
			win_cfg = WIN_W'(1);
		end else if (int'(cfg_wr_data) > MAX_WINDOW) begin
			win_cfg = WIN_W'(MAX_WINDOW);
		end else begin
			win_cfg = WIN_W'(cfg_wr_data);
		end
	end

	// sample ring; read is issued at the input transfer, data valid in ST_RD
	rbma_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == ST_RD),
		.wr_addr (slot_q),
		.wr_data (sample_q),
		.rd_en   (in_xfer),
		.rd_addr (pos_q),
		.rd_data (ram_rd_data)
	);

	// a slot never written since the last clear reads as zero
	assign old_sample = slot_vld_q[slot_q] ? ram_rd_data : '0;
	assign sum_new    = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
	assign pos_inc    = WIN_W'(slot_q) + 1'b1;
	assign div_start  = (state_q == ST_RD);

	rbma_div #(
		.DVD_W (SUM_W),
		.DVS_W (WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_new),
		.divisor  (win_q),
		.quotient (div_quo),
		.status   (div_stat)
	);

	// control and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			win_q      <= WIN_W'(WIN_RST);
			pos_q      <= '0;
			sum_q      <= '0;
			slot_vld_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				win_q      <= win_cfg;
				pos_q      <= '0;
				sum_q      <= '0;
				slot_vld_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// read-modify-write of the slot, then advance the position
					sum_q              <= sum_new;
					slot_vld_q[slot_q] <= 1'b1;
					pos_q              <= (pos_inc == win_q) ? '0 : pos_inc[PTR_W-1:0];
					state_q            <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample and slot of the item in flight
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= sample_value;
			slot_q   <= pos_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == ST_DIV) && div_stat.done) || (state_q == ST_HOLD)) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((((state_q == ST_DIV) && div_stat.done) || (state_q == ST_HOLD)) && out_free) begin
			avg_q      <= div_quo[SAMPLE_BITS-1:0];
			slot_out_q <= rbma_pkg::SLOT_W'(slot_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign window_average = avg_q;
	assign slot_written   = slot_out_q;

`ifndef SYNTH
	// a sample transfer always starts the slot read-modify-write next
	a_xfer_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_RD))
		else $error("sample transfer not followed by slot update");

	// a new result appears only when the divider has delivered
	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |->
			($past(state_q) == ST_DIV || $past(state_q) == ST_HOLD))
		else $error("result presented without a finished division");

	// write position stays inside the active window
	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(WIN_W'(pos_q) < win_q))
		else $error("write position outside the window");

	// divider only runs while the sequencer waits on it
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside the divide state");
`endif

endmodule
